[sv/irpcd_pkg.sv]
// Shared types, constants and register map of the IR pulse command decoder.
package irpcd_pkg;

    // Frame layout: start slot, address slots (skipped), eight command slots
    localparam int ADDRESS_BITS   = 16;
    localparam int CMD_BITS       = 8;
    localparam int FRAME_SLOTS_I  = 1 + ADDRESS_BITS + CMD_BITS;
    localparam int CNT_W          = $clog2(FRAME_SLOTS_I + 1);
    localparam int POS_W          = $clog2(CMD_BITS);

    localparam logic [CNT_W-1:0] CMD_FIRST_SLOT = CNT_W'(1 + ADDRESS_BITS);
    localparam logic [CNT_W-1:0] FRAME_SLOTS    = CNT_W'(FRAME_SLOTS_I);

    localparam int TICK_W   = 8;
    localparam int OUT_W    = 3;
    localparam int NUM_REGS = 7;
    localparam int PDATA_W  = 32;
    localparam int IDX_W    = $clog2(NUM_REGS + 1);
    localparam int PADDR_W  = IDX_W + 2;

    localparam logic [TICK_W-1:0] RST_START_MIN = 8'd67;
    localparam logic [TICK_W-1:0] RST_START_MAX = 8'd71;
    localparam logic [TICK_W-1:0] RST_ONE_MIN   = 8'd24;
    localparam logic [TICK_W-1:0] RST_ONE_MAX   = 8'd26;
    localparam logic [TICK_W-1:0] RST_CODE0     = 8'h44;
    localparam logic [TICK_W-1:0] RST_CODE1     = 8'h45;
    localparam logic [TICK_W-1:0] RST_CODE2     = 8'h42;

    typedef enum logic [IDX_W-1:0] {
        REG_START_MIN = 3'd0,
        REG_START_MAX = 3'd1,
        REG_ONE_MIN   = 3'd2,
        REG_ONE_MAX   = 3'd3,
        REG_CODE0     = 3'd4,
        REG_CODE1     = 3'd5,
        REG_CODE2     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] start_min;
        logic [TICK_W-1:0] start_max;
        logic [TICK_W-1:0] one_min;
        logic [TICK_W-1:0] one_max;
        logic [TICK_W-1:0] code0;
        logic [TICK_W-1:0] code1;
        logic [TICK_W-1:0] code2;
    } t_cfg;

    typedef struct packed {
        logic [OUT_W-1:0]    out_bits;
        logic                frame_done;
        logic [CMD_BITS-1:0] command_code;
        logic                toggled;
    } t_result;

endpackage

[sv/ir_pulse_command_decoder_top.sv]
// Top level of the IR pulse command decoder: config port, decode core, result buffer.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------------
//  pulse     in         i_valid / o_stall    i_pulse_ticks
//  result    out        o_valid / i_stall    o_out_bits o_frame_done o_command_code
//                                            o_toggled
//  config    in         APB psel/penable     paddr pwdata -> prdata, pready always high
//
// One item per cycle while o_stall is low: the frame state updates at the
// accepting edge; on that same edge the result lands in the output register or skid.
// A two-entry result buffer (output register plus skid) lets an item be taken
// while the previous result is stalled; o_stall rises only when both are full.
// Reset is synchronous, active low; it returns the config, frame state and
// buffer valid flags to their defaults (buffer data is not reset).
module ir_pulse_command_decoder_top import irpcd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // pulse channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [TICK_W-1:0]   i_pulse_ticks,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [OUT_W-1:0]    o_out_bits,
    output logic                o_frame_done,
    output logic [CMD_BITS-1:0] o_command_code,
    output logic                o_toggled,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    t_cfg    cfg;
    t_result res_new;
    logic    in_acc;
    logic    out_free;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skd_valid;
    t_result r_skd;

    irpcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irpcd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (in_acc),
        .i_pulse_ticks (i_pulse_ticks),
        .i_cfg         (cfg),
        .o_result      (res_new)
    );

    assign o_stall  = r_skd_valid;
    assign in_acc   = i_valid && !r_skd_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_free) begin
            // skid holds the older item, so it drains first
            r_out_valid <= r_skd_valid || in_acc;
            r_skd_valid <= 1'b0;
        end else if (in_acc) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_valid ? r_skd : res_new;
        end else if (in_acc) begin
            r_skd <= res_new;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_bits     = r_out.out_bits;
    assign o_frame_done   = r_out.frame_done;
    assign o_command_code = r_out.command_code;
    assign o_toggled      = r_out.toggled;

endmodule

[sv/irpcd_regs.sv]
// APB configuration registers: pulse windows and the three command codes.
module irpcd_regs import irpcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;
    logic [TICK_W-1:0] rd_byte;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_min <= RST_START_MIN;
            r_cfg.start_max <= RST_START_MAX;
            r_cfg.one_min   <= RST_ONE_MIN;
            r_cfg.one_max   <= RST_ONE_MAX;
            r_cfg.code0     <= RST_CODE0;
            r_cfg.code1     <= RST_CODE1;
            r_cfg.code2     <= RST_CODE2;
        end else if (wr_en) begin
            unique case (idx)
                REG_START_MIN: r_cfg.start_min <= pwdata[TICK_W-1:0];
                REG_START_MAX: r_cfg.start_max <= pwdata[TICK_W-1:0];
                REG_ONE_MIN:   r_cfg.one_min   <= pwdata[TICK_W-1:0];
                REG_ONE_MAX:   r_cfg.one_max   <= pwdata[TICK_W-1:0];
                REG_CODE0:     r_cfg.code0     <= pwdata[TICK_W-1:0];
                REG_CODE1:     r_cfg.code1     <= pwdata[TICK_W-1:0];
                REG_CODE2:     r_cfg.code2     <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_START_MIN: rd_byte = r_cfg.start_min;
            REG_START_MAX: rd_byte = r_cfg.start_max;
            REG_ONE_MIN:   rd_byte = r_cfg.one_min;
            REG_ONE_MAX:   rd_byte = r_cfg.one_max;
            REG_CODE0:     rd_byte = r_cfg.code0;
            REG_CODE1:     rd_byte = r_cfg.code1;
            REG_CODE2:     rd_byte = r_cfg.code2;
            default:       rd_byte = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-TICK_W){1'b0}}, rd_byte};
    assign o_cfg  = r_cfg;

endmodule

[sv/irpcd_core.sv]
// Frame state and per-pulse decode: start detect, command bit capture, code match.
module irpcd_core import irpcd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [TICK_W-1:0] i_pulse_ticks,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic                r_in_frame;
    logic [CNT_W-1:0]    r_bit_count;
    logic [CMD_BITS-1:0] r_command;
    logic [OUT_W-1:0]    r_outputs;

    logic                n_in_frame;
    logic [CNT_W-1:0]    n_bit_count;
    logic [CMD_BITS-1:0] n_command;
    logic [OUT_W-1:0]    n_outputs;

    logic                start_hit;
    logic                one_hit;
    logic [CNT_W-1:0]    slot;
    logic [CNT_W-1:0]    slot_next;
    logic [POS_W-1:0]    pos;
    logic                done;
    logic                hit;

    assign start_hit = (i_pulse_ticks >= i_cfg.start_min) && (i_pulse_ticks <= i_cfg.start_max);
    assign one_hit   = (i_pulse_ticks >= i_cfg.one_min) && (i_pulse_ticks <= i_cfg.one_max);
    assign slot      = start_hit ? '0 : r_bit_count;
    assign slot_next = slot + CNT_W'(1);
    assign pos       = POS_W'(slot - CMD_FIRST_SLOT);

    always_comb begin
        n_in_frame  = r_in_frame | start_hit;
        n_bit_count = slot;
        n_command   = start_hit ? '0 : r_command;
        n_outputs   = r_outputs;
        done        = 1'b0;
        hit         = 1'b0;
        if (n_in_frame) begin
            if (slot >= CMD_FIRST_SLOT && slot < FRAME_SLOTS && one_hit) begin
                n_command[pos] = 1'b1;
            end
            n_bit_count = slot_next;
            if (slot_next >= FRAME_SLOTS) begin
                done = 1'b1;
                // lowest-numbered matching code wins
                if (n_command == i_cfg.code0) begin
                    n_outputs[0] = ~r_outputs[0];
                    hit          = 1'b1;
                end else if (n_command == i_cfg.code1) begin
                    n_outputs[1] = ~r_outputs[1];
                    hit          = 1'b1;
                end else if (n_command == i_cfg.code2) begin
                    n_outputs[2] = ~r_outputs[2];
                    hit          = 1'b1;
                end
                n_in_frame  = 1'b0;
                n_bit_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_bit_count <= '0;
            r_command   <= '0;
            r_outputs   <= '0;
        end else if (i_en) begin
            r_in_frame  <= n_in_frame;
            r_bit_count <= n_bit_count;
            r_command   <= n_command;
            r_outputs   <= n_outputs;
        end
    end

    assign o_result = {n_outputs, done, n_command, hit};

endmodule

[sv/irpcd_checker.sv]
// Port-level checks for the IR pulse command decoder, bound to the top level.
module irpcd_checker import irpcd_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [OUT_W-1:0]    o_out_bits,
    input logic                o_frame_done,
    input logic                o_toggled
);

    // a held result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a toggle only happens on a completed frame
    a_toggle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_toggled |-> o_frame_done)
        else $error("toggle without frame completion");

    // input side stalls only when both buffer slots are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall with empty output register");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("buffer not empty after reset");

endmodule

bind ir_pulse_command_decoder_top irpcd_checker u_irpcd_checker (.*);
